FILE: design/dppc_pkg.sv
// ----------------------------------------------------------------------------
// dppc_pkg: shared types and constants of the drive position controller
// Operation codes, error codes, register indexes, queue entry and sequencer
// state types used by the front end, the queue and the execution back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dppc_pkg;

    // Fixed point: fraction bits of every Q value
    localparam int FRAC_BITS = 16;
    localparam int FRAC2     = 2 * FRAC_BITS;

    // Stream packing
    localparam int IN_TDATA_W  = 176;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_PAD_W   = 4;

    // Register reset values
    localparam logic [31:0] CFG_UNITY_RESET = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] DEADBAND_RESET  = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [31:0] MAX_LIMIT_RESET = 32'hFFFF_FFFF;
    localparam logic [15:0] CONTROL_RESET   = 16'h0006;

    // Status word bits
    localparam int ST_READY_BIT = 0;
    localparam int ST_ON_BIT    = 1;
    localparam int ST_FAULT_BIT = 3;

    // Control word bits
    localparam int          CW_SWITCH_ON_BIT = 0;
    localparam int          CW_ENABLE_BIT    = 3;
    localparam logic [15:0] CW_MOVABLE       = 16'h0009;

    // Signed 48-bit position limits
    localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] POS_MIN = 48'h8000_0000_0000;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_FEEDBACK   = 3'd0,
        OP_VELOCITY   = 3'd1,
        OP_TARGET     = 3'd2,
        OP_SWITCH_ON  = 3'd3,
        OP_ENABLE     = 3'd4,
        OP_SWITCH_OFF = 3'd5,
        OP_DISABLE    = 3'd6,
        OP_HOME       = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_FAULT     = 3'd1,
        ERR_NOT_READY = 3'd2,
        ERR_NOT_ON    = 3'd3,
        ERR_LIMIT     = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        CFG_POS_SCALE = 3'd0,
        CFG_GAIN      = 3'd1,
        CFG_VEL_SCALE = 3'd2,
        CFG_DEADBAND  = 3'd3,
        CFG_MAX_LIMIT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] pos_scale;
        logic [31:0] gain;
        logic [31:0] vel_scale;
        logic [31:0] deadband;
        logic [31:0] max_limit;
    } cfg_t;

    // One classified word waiting for the back end
    typedef struct packed {
        op_t         op;
        logic        raw_neg;
        logic [31:0] raw_mag;
        logic [15:0] torque;
        logic [15:0] status;
        logic [31:0] direct_velocity;
        logic [47:0] target;
        logic [31:0] speed_limit;
        logic        lim_over;
    } entry_t;

    typedef struct packed {
        logic [47:0] position;
        logic        move_done;
        err_t        error;
        logic [15:0] control;
        logic [31:0] velocity;
    } result_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_EXEC,
        BK_POS,
        BK_ERR,
        BK_DEAD,
        BK_MUL_HI,
        BK_CLAMP,
        BK_MUL_V,
        BK_SAT,
        BK_OUT
    } bk_state_t;

endpackage

`default_nettype wire

FILE: design/dppc_front.sv
// ----------------------------------------------------------------------------
// dppc_front: input stage
// Accept stream words, unpack and classify them, and push them into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dppc_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [dppc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [2:0]                       s_axis_tuser,
    input  wire logic [31:0]                      max_limit,
    output logic                                  push,
    output dppc_pkg::entry_t                      push_data,
    input  wire logic                             q_full
);

    logic             hold_valid_reg;
    logic             hold_valid_next;
    dppc_pkg::entry_t hold_reg;
    dppc_pkg::entry_t entry_next;
    logic             accept;
    logic [31:0]      raw;

    assign push          = hold_valid_reg && !q_full;
    assign s_axis_tready = !hold_valid_reg || !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_data     = hold_reg;

    assign raw = s_axis_tdata[31:0];

    always_comb
    begin
        entry_next.op              = dppc_pkg::op_t'(s_axis_tuser);
        entry_next.raw_neg         = raw[31];
        entry_next.raw_mag         = raw[31] ? (~raw + 32'd1) : raw;
        entry_next.torque          = s_axis_tdata[47:32];
        entry_next.status          = s_axis_tdata[63:48];
        entry_next.direct_velocity = s_axis_tdata[95:64];
        entry_next.target          = s_axis_tdata[143:96];
        entry_next.speed_limit     = s_axis_tdata[175:144];
        // Limit check done here; the user must let registers only change while nothing is queued (not enforced)
        entry_next.lim_over        = s_axis_tdata[175:144] > max_limit;
    end

    assign hold_valid_next = accept || (hold_valid_reg && q_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= entry_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/dppc_queue.sv
// ----------------------------------------------------------------------------
// dppc_queue: command queue
// Short FIFO of classified words between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dppc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire dppc_pkg::entry_t push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output dppc_pkg::entry_t      head_data
);

    localparam logic [dppc_pkg::QPTR_W-1:0] LAST_PTR = dppc_pkg::QPTR_W'(dppc_pkg::QUEUE_DEPTH - 1);
    localparam logic [dppc_pkg::QCNT_W-1:0] FULL_CNT = dppc_pkg::QCNT_W'(dppc_pkg::QUEUE_DEPTH);

    dppc_pkg::entry_t              slot_reg [dppc_pkg::QUEUE_DEPTH];
    logic [dppc_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [dppc_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [dppc_pkg::QCNT_W-1:0]   count_reg;
    logic [dppc_pkg::QCNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/dppc_back.sv
// ----------------------------------------------------------------------------
// dppc_back: execution back end
// Sequencer around one shared 32x32 multiplier: position scaling, the
// proportional step with deadband and clamp, drive state operations and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dppc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dppc_pkg::cfg_t   cfg,
    input  wire logic             q_valid,
    input  wire dppc_pkg::entry_t q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output dppc_pkg::result_t     out_data
);

    dppc_pkg::bk_state_t state_reg;
    dppc_pkg::bk_state_t state_next;

    // Architectural state
    logic [15:0]       control_reg;
    logic [15:0]       status_reg;
    logic [47:0]       position_reg;
    logic [15:0]       torque_reg;
    logic [31:0]       velocity_reg;
    logic [31:0]       limit_reg;
    logic              idle_reg;
    logic [47:0]       setpoint_reg;
    logic [47:0]       home_reg;
    dppc_pkg::err_t    err_reg;

    // Working registers
    dppc_pkg::entry_t  cur_reg;
    logic [63:0]       prod_reg;
    logic [47:0]       hi_reg;
    logic [47:0]       mag_reg;
    logic              mag_neg_reg;
    logic [31:0]       m_reg;
    logic              out_valid_reg;
    dppc_pkg::result_t out_reg;

    logic              out_load;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       mul_p;
    logic [47:0]       pos_sat;
    logic [48:0]       err_diff;
    logic [47:0]       err_mag;
    logic              in_band;
    logic [79:0]       gain_full;
    logic [79:0]       m_full;
    logic [31:0]       m_clamp;
    logic [63:0]       v_full;
    logic [31:0]       vel_sat;
    logic [48:0]       target_sum;
    logic [47:0]       target_sat;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign mul_p     = mul_a * mul_b;

    // Sequencer: next state, multiplier operands, queue pop, result load
    always_comb
    begin
        state_next = state_reg;
        mul_a      = 32'd0;
        mul_b      = 32'd0;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            dppc_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = dppc_pkg::BK_EXEC;
                end
            end
            dppc_pkg::BK_EXEC:
            begin
                mul_a      = cur_reg.raw_mag;
                mul_b      = cfg.pos_scale;
                state_next = (cur_reg.op == dppc_pkg::OP_FEEDBACK) ? dppc_pkg::BK_POS
                                                                   : dppc_pkg::BK_OUT;
            end
            dppc_pkg::BK_POS:
            begin
                state_next = idle_reg ? dppc_pkg::BK_OUT : dppc_pkg::BK_ERR;
            end
            dppc_pkg::BK_ERR:
            begin
                state_next = dppc_pkg::BK_DEAD;
            end
            dppc_pkg::BK_DEAD:
            begin
                mul_a      = mag_reg[31:0];
                mul_b      = cfg.gain;
                state_next = in_band ? dppc_pkg::BK_OUT : dppc_pkg::BK_MUL_HI;
            end
            dppc_pkg::BK_MUL_HI:
            begin
                mul_a      = {16'd0, mag_reg[47:32]};
                mul_b      = cfg.gain;
                state_next = dppc_pkg::BK_CLAMP;
            end
            dppc_pkg::BK_CLAMP:
            begin
                state_next = dppc_pkg::BK_MUL_V;
            end
            dppc_pkg::BK_MUL_V:
            begin
                mul_a      = m_reg;
                mul_b      = cfg.vel_scale;
                state_next = dppc_pkg::BK_SAT;
            end
            dppc_pkg::BK_SAT:
            begin
                state_next = dppc_pkg::BK_OUT;
            end
            dppc_pkg::BK_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = dppc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = dppc_pkg::BK_IDLE;
            end
        endcase
    end

    // Scaled position, saturated to 48 bits signed
    always_comb
    begin
        if (cur_reg.raw_neg)
        begin
            pos_sat = (prod_reg > {16'd0, dppc_pkg::POS_MIN}) ? dppc_pkg::POS_MIN
                                                              : 48'(~prod_reg[47:0] + 48'd1);
        end
        else
        begin
            pos_sat = (prod_reg > {16'd0, dppc_pkg::POS_MAX}) ? dppc_pkg::POS_MAX
                                                              : prod_reg[47:0];
        end
    end

    assign err_diff = {setpoint_reg[47], setpoint_reg} - {position_reg[47], position_reg};
    assign err_mag  = err_diff[48] ? 48'(~err_diff + 49'd1) : err_diff[47:0];
    // Strict window: a zero deadband never ends a move
    assign in_band  = mag_reg < {16'd0, cfg.deadband};

    // Full 80-bit gain product; anything past the limit clamps to it
    assign gain_full = {16'd0, prod_reg} + {hi_reg, 32'd0};
    assign m_full    = gain_full >> dppc_pkg::FRAC_BITS;
    assign m_clamp   = (m_full >= {48'd0, limit_reg}) ? limit_reg : m_full[31:0];

    assign v_full = prod_reg >> dppc_pkg::FRAC2;

    always_comb
    begin
        if (mag_neg_reg)
        begin
            vel_sat = (v_full >= 64'h8000_0000) ? 32'h8000_0000 : (~v_full[31:0] + 32'd1);
        end
        else
        begin
            vel_sat = (v_full > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v_full[31:0];
        end
    end

    assign target_sum = {cur_reg.target[47], cur_reg.target} + {home_reg[47], home_reg};

    always_comb
    begin
        if (target_sum[48] != target_sum[47])
        begin
            target_sat = target_sum[48] ? dppc_pkg::POS_MIN : dppc_pkg::POS_MAX;
        end
        else
        begin
            target_sat = target_sum[47:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dppc_pkg::BK_IDLE;
            control_reg   <= dppc_pkg::CONTROL_RESET;
            status_reg    <= 16'd0;
            position_reg  <= 48'd0;
            torque_reg    <= 16'd0;
            velocity_reg  <= 32'd0;
            limit_reg     <= dppc_pkg::MAX_LIMIT_RESET;
            idle_reg      <= 1'b1;
            setpoint_reg  <= 48'd0;
            home_reg      <= 48'd0;
            err_reg       <= dppc_pkg::ERR_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                dppc_pkg::BK_EXEC:
                begin
                    err_reg <= dppc_pkg::ERR_OK;
                    case (cur_reg.op)
                        dppc_pkg::OP_FEEDBACK:
                        begin
                            torque_reg <= cur_reg.torque;
                            status_reg <= cur_reg.status;
                        end
                        dppc_pkg::OP_VELOCITY:
                        begin
                            velocity_reg <= cur_reg.direct_velocity;
                            idle_reg     <= 1'b1;
                        end
                        dppc_pkg::OP_TARGET:
                        begin
                            if (cur_reg.lim_over)
                            begin
                                err_reg <= dppc_pkg::ERR_LIMIT;
                            end
                            else
                            begin
                                setpoint_reg <= target_sat;
                                limit_reg    <= cur_reg.speed_limit;
                                idle_reg     <= 1'b0;
                            end
                        end
                        dppc_pkg::OP_SWITCH_ON:
                        begin
                            if (status_reg[dppc_pkg::ST_FAULT_BIT])
                            begin
                                err_reg <= dppc_pkg::ERR_FAULT;
                            end
                            else if (!status_reg[dppc_pkg::ST_READY_BIT])
                            begin
                                err_reg <= dppc_pkg::ERR_NOT_READY;
                            end
                            else
                            begin
                                control_reg[dppc_pkg::CW_SWITCH_ON_BIT] <= 1'b1;
                            end
                        end
                        dppc_pkg::OP_ENABLE:
                        begin
                            if (status_reg[dppc_pkg::ST_FAULT_BIT])
                            begin
                                err_reg <= dppc_pkg::ERR_FAULT;
                            end
                            else if (!status_reg[dppc_pkg::ST_ON_BIT])
                            begin
                                err_reg <= dppc_pkg::ERR_NOT_ON;
                            end
                            else
                            begin
                                control_reg[dppc_pkg::CW_ENABLE_BIT] <= 1'b1;
                            end
                        end
                        dppc_pkg::OP_SWITCH_OFF:
                        begin
                            control_reg[dppc_pkg::CW_ENABLE_BIT]    <= 1'b0;
                            control_reg[dppc_pkg::CW_SWITCH_ON_BIT] <= 1'b0;
                        end
                        dppc_pkg::OP_DISABLE:
                        begin
                            control_reg[dppc_pkg::CW_ENABLE_BIT] <= 1'b0;
                        end
                        default:
                        begin
                            home_reg <= position_reg;
                        end
                    endcase
                end
                dppc_pkg::BK_POS:
                begin
                    position_reg <= pos_sat;
                end
                dppc_pkg::BK_DEAD:
                begin
                    if (in_band)
                    begin
                        idle_reg     <= 1'b1;
                        velocity_reg <= 32'd0;
                    end
                end
                dppc_pkg::BK_SAT:
                begin
                    velocity_reg <= vel_sat;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        case (state_reg)
            dppc_pkg::BK_EXEC,
            dppc_pkg::BK_DEAD,
            dppc_pkg::BK_MUL_V:
            begin
                prod_reg <= mul_p;
            end
            dppc_pkg::BK_MUL_HI:
            begin
                hi_reg <= mul_p[47:0];
            end
            dppc_pkg::BK_ERR:
            begin
                mag_reg     <= err_mag;
                mag_neg_reg <= err_diff[48];
            end
            dppc_pkg::BK_CLAMP:
            begin
                m_reg <= m_clamp;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_reg.velocity  <= velocity_reg;
            out_reg.control   <= control_reg;
            out_reg.error     <= err_reg;
            out_reg.move_done <= idle_reg;
            out_reg.position  <= position_reg;
        end
    end

    // An arrival inside the window ends the move with zero velocity
    a_band_ends_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dppc_pkg::BK_DEAD && in_band) |=> (idle_reg && velocity_reg == 32'd0))
        else $error("deadband arrival did not end the move");

    // The clamped magnitude never exceeds the move's speed limit
    a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dppc_pkg::BK_CLAMP) |=> (m_reg <= limit_reg))
        else $error("clamped magnitude above speed limit");

    // Only switch-on and enable bits of the control word ever move
    a_ctrl_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (control_reg & ~dppc_pkg::CW_MOVABLE)
            == (dppc_pkg::CONTROL_RESET & ~dppc_pkg::CW_MOVABLE))
        else $error("fixed control word bits changed");

    // A popped word is executed in the next cycle
    a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == dppc_pkg::BK_EXEC))
        else $error("popped word not executed");

endmodule

`default_nettype wire

FILE: design/drive_position_p_controller_unit.sv
// ----------------------------------------------------------------------------
// drive_position_p_controller_unit: servo drive position loop
// Proportional position controller with deadband and a drive control word.
//
// Usage:
//   s_axis: one command word per handshake. tuser holds the operation;
//     tdata holds the feedback, velocity, target and speed limit fields.
//     The operation selects which fields matter.
//   m_axis: exactly one result word per command, in command order, holding
//     the velocity command, control word, error code, move-done flag and
//     the scaled position.
//   cfg: write enable, register index and 32-bit data; a write lands at the
//     clock edge. Write only while no command is in flight.
//   Flow: input stage, queue, then back end, one command at a time through
//     its single shared 32x32 multiplier, which sets the rate. Feedback adds
//     position scaling; with a move running, error and deadband, then unless
//     in the window, gain, clamp, velocity multiply and saturation.
//   Stall: with m_axis_tready low the result register holds its word and
//     the input stage plus a two-deep queue keep taking commands until full.
//   Reset: state and config registers take their reset values, control word 0x0006,
//     no move active, queue empty, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drive_position_p_controller_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // tdata: raw_position[31:0], raw_torque[47:32], status_in[63:48],
    //        direct_velocity[95:64], target_position[143:96], speed_limit[175:144]
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [dppc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: operation[2:0]
    input  wire logic [2:0]                        s_axis_tuser,
    // tdata: velocity_command[31:0], control_word[47:32], error_code[50:48],
    //        move_done[51], position_out[99:52], zero[103:100]
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [dppc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [2:0]                        cfg_index,
    input  wire logic [31:0]                       cfg_data
);

    dppc_pkg::cfg_t    cfg_reg;
    logic              push;
    dppc_pkg::entry_t  push_data;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    dppc_pkg::entry_t  q_data;
    dppc_pkg::result_t result;

    // Register file: hold values until written; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_scale <= dppc_pkg::CFG_UNITY_RESET;
            cfg_reg.gain      <= dppc_pkg::CFG_UNITY_RESET;
            cfg_reg.vel_scale <= dppc_pkg::CFG_UNITY_RESET;
            cfg_reg.deadband  <= dppc_pkg::DEADBAND_RESET;
            cfg_reg.max_limit <= dppc_pkg::MAX_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dppc_pkg::CFG_POS_SCALE: cfg_reg.pos_scale <= cfg_data;
                dppc_pkg::CFG_GAIN:      cfg_reg.gain      <= cfg_data;
                dppc_pkg::CFG_VEL_SCALE: cfg_reg.vel_scale <= cfg_data;
                dppc_pkg::CFG_DEADBAND:  cfg_reg.deadband  <= cfg_data;
                dppc_pkg::CFG_MAX_LIMIT: cfg_reg.max_limit <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front: accept and classify commands
    dppc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .max_limit     (cfg_reg.max_limit),
        .push          (push),
        .push_data     (push_data),
        .q_full        (q_full)
    );

    // Queue: decouple the input stage from the sequencer
    dppc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data)
    );

    // Back: execute commands and drive the result register
    dppc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    // Pack the result word, lowest field first
    assign m_axis_tdata = {{dppc_pkg::OUT_PAD_W{1'b0}}, result};

endmodule

`default_nettype wire
